### hdl/spq_pkg.sv
package spq_pkg;

  // word widths
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int OccW    = 7;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNDERFLOW = 2'd2;

  // input mode codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // value returned by a removal from an empty queue
  localparam logic signed [ValueW-1:0] EMPTY_VALUE = -32'sd1;

  // operation broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } spq_op_t;

endpackage

### hdl/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic                     clk,
  input  spq_op_t                  op,
  input  logic                     occupied,
  input  logic                     prev_ge,
  input  logic signed [ValueW-1:0] prev_entry,
  input  logic signed [ValueW-1:0] next_entry,
  output logic                     ge,
  output logic signed [ValueW-1:0] entry
);

  // held entry stays ahead of an incoming equal or smaller value
  assign ge = occupied && (entry >= op.value);

  // insert: keep, take the new value, or take the neighbor above; remove: shift up
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (!ge) begin
        entry <= prev_ge ? op.value : prev_entry;
      end
    end else if (op.rem) begin
      entry <= next_entry;
    end
  end

endmodule

### hdl/sorted_array_priority_queue.sv
// Max priority queue kept as a row of cells in descending order.
// Input channel: in_valid / in_stall carry mode and value. Mode insert places
// value behind every held entry greater than or equal to it; mode remove
// takes the largest entry out. Output channel: out_valid / out_stall carry
// removed_value, status and occupancy, one result word per input word.
// Every cell compares its entry against the broadcast value and keeps its
// entry or takes the new value, its upper or its lower neighbor's entry,
// so an insert or a removal is done in one compare and shift step, which
// sets the rate of one word per cycle while no result waits under out_stall;
// each result shows on out_valid in the cycle after acceptance. The output
// register is refilled in the same cycle it is taken, so in_stall only
// rises while a result waits under out_stall. Reset clears the fill count
// and the output valid; the cell contents are not cleared, as only entries
// below the fill count are used. A full insert returns overflow and drops
// the value; an empty removal returns underflow with value -1. Occupancy is
// the count after the word, kept to its low 7 bits.
module sorted_array_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic signed [ValueW-1:0]  value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ValueW-1:0]  removed_value,
  output logic        [StatusW-1:0] status,
  output logic        [OccW-1:0]    occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     accept;
  logic                     full;
  logic                     empty;
  spq_op_t                  op;
  logic                     ge_q    [DEPTH];
  logic signed [ValueW-1:0] entry_q [DEPTH];
  logic [CW+OccW-1:0]       occ_wide;

  // handshake: stall only while a result waits at a stalled receiver
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // operation seen by every cell
  always_comb begin
    op.ins   = accept && (mode == MODE_INSERT) && !full;
    op.rem   = accept && (mode == MODE_REMOVE) && !empty;
    op.value = value;
  end

  // fill count update
  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + CW'(1);
    end else if (op.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // row of compare and shift cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_ge;
    logic signed [ValueW-1:0] prev_entry;
    logic signed [ValueW-1:0] next_entry;
    logic                     occupied;

    assign occupied = (count > CW'(i));

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b1;
      assign prev_entry = entry_q[i];
    end else begin : g_mid
      assign prev_ge    = ge_q[i-1];
      assign prev_entry = entry_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry_q[i];
    end else begin : g_inner
      assign next_entry = entry_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .occupied   (occupied),
      .prev_ge    (prev_ge),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .ge         (ge_q[i]),
      .entry      (entry_q[i])
    );
  end

  // occupancy kept to its low bits
  assign occ_wide = {{OccW{1'b0}}, count_next};

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= occ_wide[OccW-1:0];
      if (mode == MODE_INSERT) begin
        removed_value <= '0;
        status        <= full ? STATUS_OVERFLOW : STATUS_OK;
      end else if (empty) begin
        removed_value <= EMPTY_VALUE;
        status        <= STATUS_UNDERFLOW;
      end else begin
        removed_value <= entry_q[0];
        status        <= STATUS_OK;
      end
    end
  end

endmodule
